### rtl/core/nwss_pkg.sv
package nwss_pkg;

   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int TABLE_DEPTH = 2000;
   localparam int TABLE_MID   = TABLE_DEPTH / 2;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int APB_AW      = 3;
   localparam int APB_DW      = 32;

   // register index, taken from paddr above the byte lanes
   localparam logic [APB_AW-3:0] REG_BIAS = '0;

   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } tbl_wr_type;

endpackage

### rtl/core/nwss_table_build.sv
module nwss_table_build (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 busy,
   output nwss_pkg::tbl_wr_type tbl_wr
);
   import nwss_pkg::*;

   localparam int K_W     = $clog2(TABLE_MID + 1);
   localparam int DEN_W   = 34;
   localparam int REM_W   = 50;
   localparam int STEP_W  = $clog2(DATA_W);
   localparam logic [31:0] EXP_STEP_Q32 = 32'd4252231657;
   localparam logic [DEN_W-1:0] ONE_Q32 = DEN_W'(64'h1_0000_0000);
   localparam logic [64:0] ROUND_Q32 = 65'h8000_0000;

   localparam logic [2:0] ST_LOAD_HI = 3'd0;
   localparam logic [2:0] ST_DIV_HI  = 3'd1;
   localparam logic [2:0] ST_LOAD_LO = 3'd2;
   localparam logic [2:0] ST_DIV_LO  = 3'd3;
   localparam logic [2:0] ST_MUL     = 3'd4;
   localparam logic [2:0] ST_NEXT    = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [32:0]       t_ff, t_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff, dsh_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [63:0]       prod_ff, prod_in;

   logic [DEN_W-1:0]  den;
   logic [DEN_W-1:0]  half;
   logic [REM_W-1:0]  num_hi;
   logic [REM_W-1:0]  num_lo;
   logic              ge;
   logic [64:0]       rounded;

   assign den     = {1'b0, t_ff} + ONE_Q32;
   assign half    = den >> 1;
   assign num_hi  = (REM_W'({DATA_W{1'b1}}) << 32) + REM_W'(half);
   assign num_lo  = (REM_W'(t_ff) << DATA_W) - REM_W'(t_ff) + REM_W'(half);
   assign ge      = rem_ff >= dsh_ff;
   assign rounded = {1'b0, prod_ff} + ROUND_Q32;

   assign busy = state_ff != ST_DONE;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      tbl_wr   = '0;
      unique case (state_ff)
         ST_LOAD_HI, ST_LOAD_LO: begin
            rem_in   = (state_ff == ST_LOAD_HI) ? num_hi : num_lo;
            dsh_in   = REM_W'(den) << (DATA_W - 1);
            q_in     = '0;
            step_in  = STEP_W'(DATA_W - 1);
            state_in = (state_ff == ST_LOAD_HI) ? ST_DIV_HI : ST_DIV_LO;
         end
         ST_DIV_HI, ST_DIV_LO: begin
            rem_in  = ge ? rem_ff - dsh_ff : rem_ff;
            dsh_in  = dsh_ff >> 1;
            q_in    = {q_ff[DATA_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               tbl_wr.data = {q_ff[DATA_W-2:0], ge};
               if (state_ff == ST_DIV_HI) begin
                  tbl_wr.we   = k_ff != K_W'(TABLE_MID);
                  tbl_wr.addr = IDX_W'(TABLE_MID) + IDX_W'(k_ff);
                  state_in    = ST_LOAD_LO;
               end else begin
                  tbl_wr.we   = k_ff != '0;
                  tbl_wr.addr = IDX_W'(TABLE_MID) - IDX_W'(k_ff);
                  state_in    = (k_ff == K_W'(TABLE_MID)) ? ST_DONE : ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = t_ff[31:0] * EXP_STEP_Q32;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            // t0 is exactly one, so its successor is the step constant itself
            t_in     = t_ff[32] ? {1'b0, EXP_STEP_Q32} : rounded[64:32];
            k_in     = k_ff + 1'b1;
            state_in = ST_LOAD_HI;
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD_HI;
         k_ff     <= '0;
         t_ff     <= {1'b1, 32'd0};
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         t_ff     <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

endmodule

### rtl/core/nwss_front.sv
module nwss_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                build_busy,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [nwss_pkg::DATA_W-1:0]  req_weight,
   input  logic signed [nwss_pkg::DATA_W-1:0]  req_input_value,
   input  logic                                req_last_input,
   output logic                                push_valid,
   output nwss_pkg::item_type                  push_item,
   input  logic                                push_full
);
   import nwss_pkg::*;

   logic     stg_valid_ff, stg_valid_in;
   item_type stg_item_ff, stg_item_in;
   logic     accept;
   logic     advance;

   assign advance   = ~stg_valid_ff | ~push_full;
   assign req_stall = build_busy | ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      stg_valid_in = advance ? accept : stg_valid_ff;
      stg_item_in  = stg_item_ff;
      if (accept) begin
         stg_item_in.prod = PROD_W'(req_weight) * PROD_W'(req_input_value);
         stg_item_in.last = req_last_input;
      end
   end

   assign push_valid = stg_valid_ff;
   assign push_item  = stg_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_item_ff <= stg_item_in;
   end

endmodule

### rtl/core/nwss_queue.sv
module nwss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  nwss_pkg::item_type push_item,
   output logic               push_full,
   output logic               pop_valid,
   output nwss_pkg::item_type pop_item,
   input  logic               pop
);
   import nwss_pkg::*;

   localparam int Q_DEPTH = 4;
   localparam int PTR_W   = $clog2(Q_DEPTH);
   localparam int CNT_W   = $clog2(Q_DEPTH + 1);

   item_type         mem_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign push_full = cnt_ff == CNT_W'(Q_DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~push_full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/nwss_back.sv
module nwss_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [nwss_pkg::DATA_W-1:0] bias,
   input  nwss_pkg::tbl_wr_type               tbl_wr,
   input  logic                               pop_valid,
   input  nwss_pkg::item_type                 pop_item,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nwss_pkg::DATA_W-1:0]        rsp_neuron_output
);
   import nwss_pkg::*;

   localparam int ACC_W     = 48;
   localparam int ACT_W     = ACC_W + 1;
   localparam int OFF_W     = 29;
   localparam int SCALE_W   = 7;
   localparam int SCL_W     = OFF_W + SCALE_W;
   localparam int FRAC_W    = 24;
   localparam int BIAS_SH   = 12;
   localparam int OUT_DEPTH = 8;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);
   localparam int OCNT_W    = $clog2(OUT_DEPTH + 1) + 1;

   localparam logic signed [ACT_W-1:0] TEN_Q24 = ACT_W'(167772160);
   localparam logic [SCALE_W-1:0]      SCALE   = SCALE_W'(100);

   localparam logic [1:0] CLS_MID  = 2'd0;
   localparam logic [1:0] CLS_LOW  = 2'd1;
   localparam logic [1:0] CLS_HIGH = 2'd2;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] sum_ff;
   logic signed [ACT_W-1:0] sum_wide;
   logic signed [ACC_W-1:0] sum_sat;
   logic signed [ACT_W-1:0] act;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic [OFF_W-1:0]        off_ff;
   logic [1:0]              cls2_ff, cls2_in, cls3_ff, cls4_ff;
   logic [SCL_W-1:0]        scaled;
   logic [IDX_W-1:0]        idx_ff;
   logic [DATA_W-1:0]       rd_ff;
   logic [DATA_W-1:0]       sig_mem [TABLE_DEPTH];
   logic [DATA_W-1:0]       result;

   logic [DATA_W-1:0]       out_mem_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]       owr_ptr_ff, ord_ptr_ff;
   logic [OCNT_W-1:0]       ocnt_ff, ocnt_in;
   logic [OCNT_W-1:0]       pending;
   logic                    out_pop;

   // credit: every result in flight owns a slot of the output buffer
   assign pending = ocnt_ff + OCNT_W'(v1_ff) + OCNT_W'(v2_ff) + OCNT_W'(v3_ff)
                    + OCNT_W'(v4_ff);
   assign pop = pop_valid & (~pop_item.last | (pending < OCNT_W'(OUT_DEPTH)));

   // saturating accumulate
   assign sum_wide = ACT_W'(acc_ff) + ACT_W'(pop_item.prod);
   always_comb begin
      sum_sat = sum_wide[ACC_W-1:0];
      if (sum_wide[ACT_W-1] != sum_wide[ACC_W-1]) begin
         sum_sat = {sum_wide[ACT_W-1], {(ACC_W-1){~sum_wide[ACT_W-1]}}};
      end
      acc_in = acc_ff;
      if (pop) begin
         acc_in = pop_item.last ? '0 : sum_sat;
      end
   end

   // activation and range class
   assign act = ACT_W'(sum_ff) - (ACT_W'(bias) <<< BIAS_SH);
   always_comb begin
      cls2_in = CLS_MID;
      if (act <= -TEN_Q24) begin
         cls2_in = CLS_LOW;
      end else if (act >= TEN_Q24) begin
         cls2_in = CLS_HIGH;
      end
   end

   assign scaled = SCL_W'(off_ff) * SCL_W'(SCALE);

   always_comb begin
      case (cls4_ff)
         CLS_LOW:  result = '0;
         CLS_HIGH: result = '1;
         default:  result = rd_ff;
      endcase
   end

   assign rsp_valid         = ocnt_ff != '0;
   assign rsp_neuron_output = out_mem_ff[ord_ptr_ff];
   assign out_pop           = rsp_valid & ~rsp_stall;
   assign ocnt_in           = ocnt_ff + OCNT_W'(v4_ff) - OCNT_W'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocnt_ff    <= '0;
      end else begin
         acc_ff     <= acc_in;
         v1_ff      <= pop & pop_item.last;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         owr_ptr_ff <= v4_ff ? owr_ptr_ff + 1'b1 : owr_ptr_ff;
         ord_ptr_ff <= out_pop ? ord_ptr_ff + 1'b1 : ord_ptr_ff;
         ocnt_ff    <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sum_ff <= sum_sat;
      end
      off_ff  <= OFF_W'(act + TEN_Q24);
      cls2_ff <= cls2_in;
      idx_ff  <= scaled[FRAC_W +: IDX_W];
      cls3_ff <= cls2_ff;
      cls4_ff <= cls3_ff;
      if (v4_ff) begin
         out_mem_ff[owr_ptr_ff] <= result;
      end
   end

   // sigmoid table
   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         sig_mem[tbl_wr.addr] <= tbl_wr.data;
      end
      rd_ff <= sig_mem[idx_ff];
   end

endmodule

### rtl/core/neuron_weighted_sum_sigmoid_unit.sv
// Perceptron neuron: each req beat carries one fan-in connection (weight and
// input value, signed Q4.12, plus a last flag); the products are summed in a
// saturating signed Q24.24 accumulator, and on the last beat the bias register
// (Q4.12, written at byte address 0 over the APB port) is subtracted and one
// rsp beat returns the sigmoid in unsigned Q0.16 from a 2000-entry table, 0 at
// or below -10 and 65535 at or above +10; the accumulator then clears. After
// reset the block computes that table itself with one multiplier and a
// radix-2 divider, holding req_stall high until it is done. From then on it
// takes one beat per clock cycle unless the queue is full; a last beat passes
// through the multiply, queue, accumulate, range, index and table-read stages
// before its result enters an eight-entry result buffer, which lets input keep
// flowing while rsp_stall is high until that buffer fills.
module neuron_weighted_sum_sigmoid_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [nwss_pkg::DATA_W-1:0]  req_weight,
   input  logic signed [nwss_pkg::DATA_W-1:0]  req_input_value,
   input  logic                                req_last_input,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nwss_pkg::DATA_W-1:0]         rsp_neuron_output,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nwss_pkg::APB_AW-1:0]         paddr,
   input  logic [nwss_pkg::APB_DW-1:0]         pwdata,
   output logic [nwss_pkg::APB_DW-1:0]         prdata,
   output logic                                pready
);
   import nwss_pkg::*;

   logic signed [DATA_W-1:0] bias_ff, bias_in;
   logic                     reg_sel;
   logic                     build_busy;
   tbl_wr_type               tbl_wr;
   logic                     push_valid;
   item_type                 push_item;
   logic                     push_full;
   logic                     pop_valid;
   item_type                 pop_item;
   logic                     pop;

   assign pready  = 1'b1;
   assign reg_sel = paddr[APB_AW-1:2] == REG_BIAS;
   assign prdata  = reg_sel ? APB_DW'(bias_ff) : '0;

   always_comb begin
      bias_in = bias_ff;
      if (psel & penable & pwrite & pready & reg_sel) begin
         bias_in = pwdata[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   nwss_table_build u_build (
      .clock  (clock),
      .reset  (reset),
      .busy   (build_busy),
      .tbl_wr (tbl_wr)
   );

   nwss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .build_busy      (build_busy),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_weight      (req_weight),
      .req_input_value (req_input_value),
      .req_last_input  (req_last_input),
      .push_valid      (push_valid),
      .push_item       (push_item),
      .push_full       (push_full)
   );

   nwss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   nwss_back u_back (
      .clock             (clock),
      .reset             (reset),
      .bias              (bias_ff),
      .tbl_wr            (tbl_wr),
      .pop_valid         (pop_valid),
      .pop_item          (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_neuron_output (rsp_neuron_output)
   );

endmodule

### dv/neuron_weighted_sum_sigmoid_unit_test.sv
`timescale 1ns / 1ps

module neuron_weighted_sum_sigmoid_unit_test;
   import nwss_pkg::*;

   localparam longint TEN_Q24      = 167772160;
   localparam longint ONE_Q24      = 16777216;
   localparam longint ACC_HI       = 64'sh7FFF_FFFF_FFFF;
   localparam longint ACC_LO       = -ACC_HI - 1;
   localparam int     DRAIN_CYCLES = 16;
   localparam int     RUN_LIMIT    = 3000000;
   localparam int     RANDOM_ITEMS = 1000;
   localparam int     PHASES       = 6;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     TAIL_ITEMS   = 150;
   localparam logic [APB_AW-1:0] BIAS_ADDR = {REG_BIAS, 2'b00};

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     typed;
      logic [DATA_W-1:0]        out;
   } probe_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [DATA_W-1:0]   req_weight = '0;
   logic signed [DATA_W-1:0]   req_input_value = '0;
   logic                       req_last_input = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [DATA_W-1:0]          rsp_neuron_output;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [APB_AW-1:0]          paddr = '0;
   logic [APB_DW-1:0]          pwdata = '0;
   logic [APB_DW-1:0]          prdata;
   logic                       pready;

   neuron_weighted_sum_sigmoid_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_weight        (req_weight),
      .req_input_value   (req_input_value),
      .req_last_input    (req_last_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_neuron_output (rsp_neuron_output),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #1 clock = ~clock;

   logic [DATA_W-1:0] sigmoid_lut [TABLE_DEPTH];
   longint            weighted_sum = 0;
   longint            bias_q12 = 0;
   logic [DATA_W-1:0] pending_outputs [$];

   int mismatch_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int bias_writes = 0;
   int backpressure_cycles = 0;
   int hold_asked = 0;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   bit quiet_tail = 1'b0;

   probe_row_type directed_rows [20];

   task automatic report_mismatch(input string what);
      if (mismatch_count < 30) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic void build_sigmoid_lut();
      bit [63:0] decay [0:1000];
      bit [63:0] num;
      bit [63:0] den;
      bit [63:0] tk;
      decay[0] = 64'h1_0000_0000;
      for (int k = 1; k <= 1000; k++) begin
         decay[k] = (decay[k-1] * 64'd4252231657 + 64'h8000_0000) >> 32;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i >= TABLE_MID) begin
            tk  = decay[i - TABLE_MID];
            num = 64'd65535 << 32;
         end else begin
            tk  = decay[TABLE_MID - i];
            num = 64'd65535 * tk;
         end
         den = 64'h1_0000_0000 + tk;
         sigmoid_lut[i] = DATA_W'((num + den / 2) / den);
      end
   endfunction

   function automatic logic [DATA_W-1:0] sigmoid_of(input longint act);
      longint slot;
      if (act <= -TEN_Q24) return '0;
      if (act >= TEN_Q24) return '1;
      slot = ((act + TEN_Q24) * 100) / ONE_Q24;
      if (slot < 0) slot = 0;
      if (slot > TABLE_DEPTH - 1) slot = TABLE_DEPTH - 1;
      return sigmoid_lut[slot];
   endfunction

   // saturating mac; on the last beat fold in the bias and look up the sigmoid
   function automatic bit accumulate_connection(input logic signed [DATA_W-1:0] w,
                                                input logic signed [DATA_W-1:0] v,
                                                input logic last,
                                                output logic [DATA_W-1:0] y);
      longint total;
      total = weighted_sum + longint'(w) * longint'(v);
      if (total > ACC_HI) total = ACC_HI;
      if (total < ACC_LO) total = ACC_LO;
      weighted_sum = total;
      y = '0;
      if (!last) return 1'b0;
      y = sigmoid_of(weighted_sum - bias_q12 * 4096);
      weighted_sum = 0;
      return 1'b1;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value(input int style);
      case (style)
         0: return DATA_W'($urandom());
         1: return DATA_W'($urandom_range(0, 24576) - 12288);
         2: return DATA_W'($urandom_range(0, 4096) - 2048);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sd0;
               3: return 16'sd1;
               default: return -16'sd1;
            endcase
         end
      endcase
   endfunction

   task automatic offer_connection(input logic signed [DATA_W-1:0] w,
                                   input logic signed [DATA_W-1:0] v,
                                   input logic last,
                                   input logic typed,
                                   input logic [DATA_W-1:0] typed_out);
      logic [DATA_W-1:0] y;
      bit has;
      req_valid       <= 1'b1;
      req_weight      <= w;
      req_input_value <= v;
      req_last_input  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      has = accumulate_connection(w, v, last, y);
      if (has) pending_outputs.insert(pending_outputs.size(), typed ? typed_out : y);
      items_sent++;
      if (sender_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic send_neuron();
      int fan_in;
      int style;
      int s;
      fan_in = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 48) : $urandom_range(1, 6);
      style  = $urandom_range(0, 9);
      for (int n = 0; n < fan_in; n++) begin
         if (style < 3) s = 0;
         else if (style < 7) s = 1;
         else if (style < 9) s = 2;
         else s = $urandom_range(0, 3);
         offer_connection(pick_value(s), pick_value(s), n == fan_in - 1, 1'b0, '0);
      end
   endtask

   task automatic bias_access(input logic write, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= BIAS_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_bias(input logic signed [DATA_W-1:0] value);
      logic [APB_DW-1:0] rd;
      bias_access(1'b1, {{(APB_DW-DATA_W){value[DATA_W-1]}}, value}, rd);
      bias_q12 = longint'(value);
      bias_writes++;
      bias_access(1'b0, '0, rd);
      if (rd[DATA_W-1:0] !== value) begin
         report_mismatch($sformatf("bias reads back %h, wrote %h", rd[DATA_W-1:0], value));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: checks every rsp beat and drives rsp_stall
   initial begin : result_side
      int stall_left;
      int hold_served;
      logic [DATA_W-1:0] want;
      stall_left  = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_neuron_output));
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_neuron_output !== want) begin
                  report_mismatch($sformatf("neuron_output %h, expected %h",
                                            rsp_neuron_output, want));
               end
               results_seen++;
            end
         end
         if (hold_served != hold_asked) begin
            hold_served++;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && receiver_gaps && !quiet_tail &&
                      $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
         if (req_valid && req_stall === 1'b1 && items_sent > 0) backpressure_cycles++;
      end
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, pending_outputs.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic [APB_DW-1:0]        rd;
      logic signed [DATA_W-1:0] bias_plan [PHASES];
      int                       phase_target;
      build_sigmoid_lut();
      directed_rows = '{
         '{16'sd0,      16'sd0,      1'b1, 1'b1, 16'd32768},
         '{16'sh8000,   16'sh8000,   1'b1, 1'b1, 16'd65535},
         '{16'sd32767,  16'sh8000,   1'b1, 1'b1, 16'd0},
         '{16'sd20480,  -16'sd8192,  1'b1, 1'b1, 16'd0},
         '{16'sd20480,  16'sd8192,   1'b1, 1'b1, 16'd65535},
         '{16'sd20480,  16'sd8192,   1'b0, 1'b0, 16'd0},
         '{16'sd1,      -16'sd1,     1'b1, 1'b0, 16'd0},
         '{16'sd20480,  -16'sd8192,  1'b0, 1'b0, 16'd0},
         '{16'sd1,      16'sd1,      1'b1, 1'b0, 16'd0},
         '{16'sd4096,   16'sd4096,   1'b0, 1'b0, 16'd0},
         '{16'sd4096,   -16'sd8192,  1'b0, 1'b0, 16'd0},
         '{16'sd2048,   16'sd4096,   1'b1, 1'b0, 16'd0},
         '{16'sd32767,  16'sd32767,  1'b0, 1'b0, 16'd0},
         '{16'sh8000,   16'sd32767,  1'b0, 1'b0, 16'd0},
         '{16'sd1,      -16'sd1,     1'b1, 1'b0, 16'd0},
         '{16'sh8000,   16'sd0,      1'b1, 1'b1, 16'd32768},
         '{16'sd0,      16'sh8000,   1'b0, 1'b0, 16'd0},
         '{16'sd32767,  16'sd1,      1'b1, 1'b0, 16'd0},
         '{16'sd12288,  -16'sd4096,  1'b1, 1'b0, 16'd0},
         '{16'sh7fff,   16'sh7fff,   1'b1, 1'b1, 16'd65535}
      };
      bias_plan[0] = 16'sh7fff;
      bias_plan[1] = 16'sh8000;
      bias_plan[2] = DATA_W'($urandom());
      bias_plan[3] = 16'sd0;
      bias_plan[4] = DATA_W'($urandom_range(0, 4096) - 2048);
      bias_plan[5] = DATA_W'($urandom());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      bias_access(1'b0, '0, rd);
      if (rd[DATA_W-1:0] !== '0) report_mismatch($sformatf("bias after reset %h", rd));

      foreach (directed_rows[i]) begin
         offer_connection(directed_rows[i].weight, directed_rows[i].value,
                          directed_rows[i].last, directed_rows[i].typed,
                          directed_rows[i].out);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         set_bias(bias_plan[p]);
         sender_gaps   = $urandom_range(0, 3) != 0;
         receiver_gaps = $urandom_range(0, 3) != 0;
         if (p == 2) begin
            // long rsp hold-off while last beats keep coming, fills the result buffer
            sender_gaps = 1'b0;
            hold_asked++;
            repeat (64) offer_connection(pick_value(2), pick_value(1), 1'b1, 1'b0, '0);
            sender_gaps = 1'b1;
         end
         phase_target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_target) begin
            if ($urandom_range(0, 15) == 0) sender_gaps = !sender_gaps;
            if ($urandom_range(0, 15) == 0) receiver_gaps = !receiver_gaps;
            send_neuron();
         end
      end

      drain_results();
      quiet_tail   = 1'b1;
      phase_target = items_sent + TAIL_ITEMS;
      while (items_sent < phase_target) send_neuron();
      drain_results();

      $display("covered %0d connection beats, %0d neuron results, %0d bias writes",
               items_sent, results_seen, bias_writes);
      $display("with both range limits and %0d cycles of input back-pressure",
               backpressure_cycles);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### neuron_weighted_sum_sigmoid_unit.f
rtl/core/nwss_pkg.sv
rtl/core/nwss_table_build.sv
rtl/core/nwss_front.sv
rtl/core/nwss_queue.sv
rtl/core/nwss_back.sv
rtl/core/neuron_weighted_sum_sigmoid_unit.sv
dv/neuron_weighted_sum_sigmoid_unit_test.sv
